/* rtl/sbed_pkg.sv */
// Shared types, codes and constants for the short burst energy detector.
`default_nettype none

package sbed_pkg;

	// Width of one frame energy value and of the tracked base level.
	localparam int ENERGY_BITS = 16;
	localparam int COUNT_BITS  = 6;
	localparam int LIMIT_BITS  = 5;
	localparam int MARGIN_BITS = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 8;

	typedef logic [ENERGY_BITS-1:0] energy_t;
	typedef logic [ENERGY_BITS:0]   energy_wide_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [LIMIT_BITS-1:0]  limit_t;
	typedef logic [MARGIN_BITS-1:0] margin_t;

	// Detector phases.
	typedef enum logic [1:0] {
		PH_SETTLE = 2'd0,
		PH_ARMED  = 2'd1,
		PH_BURST  = 2'd2,
		PH_TAIL   = 2'd3
	} phase_t;

	// Verdict codes; code 3 carries no meaning.
	typedef enum logic [1:0] {
		V_NONE    = 2'd0,
		V_CONFIRM = 2'd1,
		V_REJECT  = 2'd2
	} verdict_t;

	// Request types.
	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIMPLE_MODE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_QUIET       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BURST_MAX   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TAIL        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRACE       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN      = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REARM       = 3'd6;

	// Reset values of the configuration registers.
	localparam limit_t  RST_QUIET     = 5'd20;
	localparam limit_t  RST_BURST_MAX = 5'd8;
	localparam limit_t  RST_TAIL      = 5'd12;
	localparam limit_t  RST_GRACE     = 5'd3;
	localparam margin_t RST_MARGIN    = 8'd1;
	localparam limit_t  RST_REARM     = 5'd20;

	// Configuration as seen by the detector core.
	typedef struct packed {
		logic    simple_mode;
		limit_t  quiet_frames_needed;
		limit_t  burst_frames_max;
		limit_t  tail_frames_needed;
		limit_t  tail_grace_frames;
		margin_t level_margin;
		limit_t  rearm_frames;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic     query_valid;
		verdict_t verdict;
		phase_t   phase_now;
	} result_t;

endpackage

`default_nettype wire

/* rtl/sbed_cfg.sv */
// Configuration register file of the short burst energy detector.
`default_nettype none

module sbed_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sbed_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [sbed_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output sbed_pkg::cfg_t                          cfg
);
	import sbed_pkg::*;

	cfg_t cfg_q;
	logic wr;

	// Writes always complete in the cycle they are offered.
	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign cfg       = cfg_q;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.simple_mode         <= 1'b0;
			cfg_q.quiet_frames_needed <= RST_QUIET;
			cfg_q.burst_frames_max    <= RST_BURST_MAX;
			cfg_q.tail_frames_needed  <= RST_TAIL;
			cfg_q.tail_grace_frames   <= RST_GRACE;
			cfg_q.level_margin        <= RST_MARGIN;
			cfg_q.rearm_frames        <= RST_REARM;
		end else if (wr) begin
			case (cfg_index)
				CFG_SIMPLE_MODE: cfg_q.simple_mode         <= cfg_data[0];
				CFG_QUIET:       cfg_q.quiet_frames_needed <= cfg_data[LIMIT_BITS-1:0];
				CFG_BURST_MAX:   cfg_q.burst_frames_max    <= cfg_data[LIMIT_BITS-1:0];
				CFG_TAIL:        cfg_q.tail_frames_needed  <= cfg_data[LIMIT_BITS-1:0];
				CFG_GRACE:       cfg_q.tail_grace_frames   <= cfg_data[LIMIT_BITS-1:0];
				CFG_MARGIN:      cfg_q.level_margin        <= cfg_data[MARGIN_BITS-1:0];
				CFG_REARM:       cfg_q.rearm_frames        <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/sbed_core.sv */
// Detector state registers and the single-pass per-item update logic.
`default_nettype none

module sbed_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   go,
	input  wire logic                   req_type,
	input  wire sbed_pkg::energy_t      frame_energy,
	input  wire sbed_pkg::cfg_t         cfg,
	output sbed_pkg::result_t           result
);
	import sbed_pkg::*;

	phase_t       phase_q, phase_d;
	energy_t      base_q, base_d;
	count_t       fc_q, fc_d;
	limit_t       rearm_q, rearm_d;
	count_t       fc_inc;
	energy_wide_t loud_ref;
	logic         loud;
	logic         below;
	verdict_t     verdict_c;
	logic         qv_c;

	// Loud compare is one bit wider so base plus margin never wraps.
	assign loud_ref = energy_wide_t'(base_q) + energy_wide_t'(cfg.level_margin);
	assign loud     = energy_wide_t'(frame_energy) > loud_ref;
	assign below    = frame_energy < base_q;
	assign fc_inc   = fc_q + count_t'(1);

	// Next state and result of the item offered this cycle.
	always_comb begin
		phase_d   = phase_q;
		base_d    = base_q;
		fc_d      = fc_q;
		rearm_d   = rearm_q;
		verdict_c = V_NONE;
		qv_c      = 1'b0;
		if (req_type == REQ_FRAME) begin
			if (cfg.simple_mode) begin
				phase_d = PH_SETTLE;
				fc_d    = '0;
				if (rearm_q != '0) begin
					rearm_d = rearm_q - limit_t'(1);
				end
			end else begin
				case (phase_q)
					PH_SETTLE: begin
						if (below) begin
							base_d = frame_energy;
							fc_d   = '0;
						end else if (loud) begin
							base_d = frame_energy - energy_t'(cfg.level_margin);
							fc_d   = '0;
						end else if (fc_inc > count_t'(cfg.quiet_frames_needed)) begin
							fc_d    = '0;
							phase_d = PH_ARMED;
						end else begin
							fc_d = fc_inc;
						end
					end
					PH_ARMED: begin
						if (below) begin
							base_d  = frame_energy;
							phase_d = PH_SETTLE;
							fc_d    = '0;
						end else if (loud) begin
							phase_d = PH_BURST;
							fc_d    = '0;
						end
					end
					PH_BURST: begin
						if (!loud) begin
							phase_d = PH_TAIL;
							fc_d    = '0;
						end else if (fc_inc > count_t'(cfg.burst_frames_max)) begin
							verdict_c = V_REJECT;
							phase_d   = PH_SETTLE;
							fc_d      = '0;
						end else begin
							fc_d = fc_inc;
						end
					end
					PH_TAIL: begin
						if (loud && (fc_q > count_t'(cfg.tail_grace_frames))) begin
							verdict_c = V_REJECT;
							phase_d   = PH_SETTLE;
							fc_d      = '0;
						end else if (fc_inc > count_t'(cfg.tail_frames_needed)) begin
							verdict_c = V_CONFIRM;
							phase_d   = PH_SETTLE;
							fc_d      = '0;
						end else begin
							fc_d = fc_inc;
						end
					end
					default: begin
						phase_d = PH_SETTLE;
						fc_d    = '0;
					end
				endcase
			end
		end else if (cfg.simple_mode) begin
			qv_c = 1'b1;
			if (rearm_q == '0) begin
				verdict_c = V_CONFIRM;
				rearm_d   = cfg.rearm_frames;
			end
		end else begin
			qv_c = (phase_q == PH_BURST) || (phase_q == PH_TAIL);
		end
	end

	// State registers advance on every transferred item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETTLE;
			base_q  <= '0;
			fc_q    <= '0;
			rearm_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			base_q  <= base_d;
			fc_q    <= fc_d;
			rearm_q <= rearm_d;
		end
	end

	assign result.query_valid = qv_c;
	assign result.verdict     = verdict_c;
	assign result.phase_now   = phase_d;

	// The armed phase never carries a frame count.
	a_armed_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ARMED |-> fc_q == '0)
		else $error("frame count nonzero while armed");

	// Simple mode frames leave the detector settling.
	a_simple_settle: assert property (@(posedge clk) disable iff (!arst_n)
		go && req_type == REQ_FRAME && cfg.simple_mode |=> phase_q == PH_SETTLE)
		else $error("simple mode frame did not settle the detector");

	// Outside simple mode a confirmation only ends a tail.
	a_confirm_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		go && !cfg.simple_mode && verdict_c == V_CONFIRM |-> phase_q == PH_TAIL)
		else $error("confirmation outside the tail phase");

	// A simple mode confirmation reloads the rearm counter.
	a_rearm_load: assert property (@(posedge clk) disable iff (!arst_n)
		go && req_type == REQ_QUERY && cfg.simple_mode && rearm_q == '0
		|=> rearm_q == $past(cfg.rearm_frames))
		else $error("rearm counter not reloaded");

endmodule

`default_nettype wire

/* rtl/sbed_out_buf.sv */
// Two-entry result buffer that decouples the output stall from the input side.
`default_nettype none

module sbed_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sbed_pkg::result_t push_data,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output sbed_pkg::result_t      out_data
);
	import sbed_pkg::*;

	result_t   mem_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;
	logic      pop;

	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid & ~out_stall;

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// The fill level tracks pushes and pops.
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("fill level did not rise on push");

	// The buffer never holds more than two results.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full result buffer");

	// With one entry held, the pointers sit one apart.
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd1 |-> wr_ptr_q != rd_ptr_q)
		else $error("pointer mismatch in result buffer");

endmodule

`default_nettype wire

/* rtl/short_burst_energy_detector.sv */
// Top level of the short burst energy detector.
`default_nettype none

// Takes one item per clock unless stalled: a frame energy (req_type 0) or a
// validity query (req_type 1), and returns exactly one result per item. Each
// item is handled by combinational update logic against the state registers,
// so a new item is accepted every clock unless the input stalls; the result
// enters a two-entry output buffer and leaves it in order once earlier
// results have gone. The input stalls whenever both buffer entries are full.
// The configuration port accepts every write at once (ready is held high)
// and must only be used while no results are outstanding.
module short_burst_energy_detector (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               req_type,
	input  wire logic [sbed_pkg::ENERGY_BITS-1:0]   frame_energy,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    query_valid,
	output logic [1:0]                              verdict,
	output logic [1:0]                              phase_now,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sbed_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [sbed_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import sbed_pkg::*;

	cfg_t    cfg;
	result_t core_res;
	result_t buf_res;
	logic    full;
	logic    go;

	// An offered item transfers whenever the buffer has room.
	assign in_stall = full;
	assign go       = in_valid & ~in_stall;

	sbed_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbed_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.req_type     (req_type),
		.frame_energy (frame_energy),
		.cfg          (cfg),
		.result       (core_res)
	);

	sbed_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.push_data (core_res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (buf_res)
	);

	// Result fields to the output ports.
	assign query_valid = buf_res.query_valid;
	assign verdict     = buf_res.verdict;
	assign phase_now   = buf_res.phase_now;

endmodule

`default_nettype wire
